// File: src/pingpong_timestamp_logger_top_assert.svh
// Assertion macros for the timestamp logger checker.
`ifndef PINGPONG_TIMESTAMP_LOGGER_TOP_ASSERT_SVH
`define PINGPONG_TIMESTAMP_LOGGER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PTL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timestamp logger assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timestamp logger assertion failed");

`endif

// File: src/ptl_pkg.sv
// Shared constants, types and the timer conversion for the timestamp logger.
`default_nettype none
package ptl_pkg;

    // Bank geometry
    localparam int BANK_DEPTH = 512;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int FILL_W     = $clog2(BANK_DEPTH + 1);
    localparam int SUM_W      = ((FILL_W > 9) ? FILL_W : 9) + 1;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 9;
    localparam int TIMER_W = 16;
    localparam int WADDR_W = 9;
    localparam int BYTES_W = 11;

    localparam logic [LEN_W-1:0] FILL_LIMIT_RESET = 9'd511;

    // One result as it sits in the output queue
    typedef struct packed {
        logic              bank;
        logic [FILL_W-1:0] addr;
        logic [DATA_W-1:0] word;
        logic              is_ts;
        logic              flush_valid;
        logic              flush_bank;
        logic [BYTES_W-1:0] flush_bytes;
        logic              dropped;
        logic              last;
    } ptl_result_t;

    // Bank write request
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ptl_wr_t;

    // Exact conversion of a 16-bit timer value to single precision
    function automatic logic [31:0] timer_to_single(input logic [TIMER_W-1:0] v);
        logic [3:0]  p;
        logic [23:0] shifted;
        logic [7:0]  expo;
        p = 4'd0;
        for (int i = 0; i < TIMER_W; i++) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        shifted = 24'({v, 7'b0}) << (5'd16 - {1'b0, p});
        expo    = 8'd127 + {4'b0, p};
        if (v == '0) begin
            timer_to_single = 32'd0;
        end else begin
            timer_to_single = {1'b0, expo, shifted[22:0]};
        end
    endfunction

endpackage
`default_nettype wire

// File: src/ptl_banks.sv
// The two word banks of the logger, one write port shared between them.
`default_nettype none
module ptl_banks (
    input  wire logic            aclk,
    input  wire ptl_pkg::ptl_wr_t wr
);
    import ptl_pkg::*;

    logic [DATA_W-1:0] bank_zero_mem [BANK_DEPTH];
    logic [DATA_W-1:0] bank_one_mem  [BANK_DEPTH];

    // Word store
    always_ff @(posedge aclk) begin
        if (wr.en && !wr.bank) begin
            bank_zero_mem[wr.addr] <= wr.data;
        end
        if (wr.en && wr.bank) begin
            bank_one_mem[wr.addr] <= wr.data;
        end
    end

endmodule
`default_nettype wire

// File: src/pingpong_timestamp_logger_top.sv
// Ping-pong timestamp logger: appends records and timestamps to two banks, flushes on limit.
//
// Each accepted record word is written to the active bank; after a record's last word the
// timer sample is written as an exact single-precision word. When a new record would push
// the bank past fill_limit, a flush descriptor (bank, byte count) rides on the first
// result of that word and the other bank becomes active. Words beyond the bank end are
// flagged as dropped and not stored. Rate: one item per cycle while each item gives one
// result and m_ready is high; an item that closes a record gives two results and holds
// s_ready low until the first leaves, since the single result port and the one bank write
// port (written as results leave) move one word per cycle. Results sit in a two-entry
// output queue, so an item is taken in the cycle its predecessor's last result leaves.
`default_nettype none
module pingpong_timestamp_logger_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [ptl_pkg::LEN_W-1:0]   cfg_wdata,
    // input channel
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [ptl_pkg::DATA_W-1:0]  s_data_word,
    input  wire logic [ptl_pkg::LEN_W-1:0]   s_record_length,
    input  wire logic [ptl_pkg::TIMER_W-1:0] s_timer_sample,
    // result channel
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic                        m_write_bank,
    output      logic [ptl_pkg::WADDR_W-1:0] m_write_address,
    output      logic [ptl_pkg::DATA_W-1:0]  m_written_word,
    output      logic                        m_is_timestamp,
    output      logic                        m_flush_valid,
    output      logic                        m_flush_bank,
    output      logic [ptl_pkg::BYTES_W-1:0] m_flush_bytes,
    output      logic                        m_dropped,
    output      logic                        m_last
);
    import ptl_pkg::*;

    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BANK_DEPTH);

    // Control state
    logic [LEN_W-1:0]  fill_limit_reg, fill_limit_next;
    logic [FILL_W-1:0] fill_zero_reg,  fill_zero_next;
    logic [FILL_W-1:0] fill_one_reg,   fill_one_next;
    logic              active_bank_reg, active_bank_next;
    logic [LEN_W-1:0]  wir_reg,        wir_next;
    logic [1:0]        cnt_reg,        cnt_next;

    // Output queue payload
    ptl_result_t slot0_reg, slot0_next;
    ptl_result_t slot1_reg, slot1_next;

    logic push, pop;

    // Item evaluation
    logic [FILL_W-1:0] fill_cur, fill_w, fill_a, fill_b;
    logic [SUM_W-1:0]  need;
    logic              flush, wbank, two, len_zero, drop0, drop1;
    logic [31:0]       stamp;
    ptl_result_t       r0, r1;
    ptl_wr_t           wr;

    assign m_valid = (cnt_reg != 2'd0);
    assign s_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    // Flush decision at record start, then up to two bank writes
    always_comb begin
        fill_cur = active_bank_reg ? fill_one_reg : fill_zero_reg;
        need     = SUM_W'(fill_cur) + SUM_W'(s_record_length) + SUM_W'(1);
        flush    = (wir_reg == '0) && (need > SUM_W'(fill_limit_reg));
        wbank    = active_bank_reg ^ flush;
        fill_w   = wbank ? fill_one_reg : fill_zero_reg;
        len_zero = (s_record_length == '0);
        two      = !len_zero &&
                   ({1'b0, wir_reg} + 10'd1 >= {1'b0, s_record_length});
        stamp    = timer_to_single(s_timer_sample);

        drop0  = (fill_w >= DEPTH_F);
        fill_a = drop0 ? fill_w : fill_w + FILL_W'(1);
        drop1  = (fill_a >= DEPTH_F);
        fill_b = drop1 ? fill_a : fill_a + FILL_W'(1);

        r0.bank        = wbank;
        r0.addr        = fill_w;
        r0.word        = len_zero ? stamp : s_data_word;
        r0.is_ts       = len_zero;
        r0.flush_valid = flush;
        r0.flush_bank  = flush & active_bank_reg;
        r0.flush_bytes = flush ? BYTES_W'({fill_cur, 2'b00}) : '0;
        r0.dropped     = drop0;
        r0.last        = !two;

        r1.bank        = wbank;
        r1.addr        = fill_a;
        r1.word        = stamp;
        r1.is_ts       = 1'b1;
        r1.flush_valid = 1'b0;
        r1.flush_bank  = 1'b0;
        r1.flush_bytes = '0;
        r1.dropped     = drop1;
        r1.last        = 1'b1;
    end

    // State update
    always_comb begin
        fill_limit_next  = cfg_we ? cfg_wdata : fill_limit_reg;
        fill_zero_next   = fill_zero_reg;
        fill_one_next    = fill_one_reg;
        active_bank_next = active_bank_reg;
        wir_next         = wir_reg;
        if (push) begin
            active_bank_next = wbank;
            if (flush && !active_bank_reg) begin
                fill_zero_next = '0;
            end
            if (flush && active_bank_reg) begin
                fill_one_next = '0;
            end
            if (wbank) begin
                fill_one_next = two ? fill_b : fill_a;
            end else begin
                fill_zero_next = two ? fill_b : fill_a;
            end
            if (len_zero || two) begin
                wir_next = '0;
            end else begin
                wir_next = wir_reg + LEN_W'(1);
            end
        end
    end

    // Output queue: new item loads only once the queue drains
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        priority if (push) begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = two ? 2'd2 : 2'd1;
        end else if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_limit_reg  <= FILL_LIMIT_RESET;
            fill_zero_reg   <= '0;
            fill_one_reg    <= '0;
            active_bank_reg <= 1'b0;
            wir_reg         <= '0;
            cnt_reg         <= 2'd0;
        end else begin
            fill_limit_reg  <= fill_limit_next;
            fill_zero_reg   <= fill_zero_next;
            fill_one_reg    <= fill_one_next;
            active_bank_reg <= active_bank_next;
            wir_reg         <= wir_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Bank write as the result is transferred
    always_comb begin
        wr.en   = pop && !slot0_reg.dropped;
        wr.bank = slot0_reg.bank;
        wr.addr = slot0_reg.addr[ADDR_W-1:0];
        wr.data = slot0_reg.word;
    end

    ptl_banks u_banks (
        .aclk (aclk),
        .wr   (wr)
    );

    // Result ports
    assign m_write_bank    = slot0_reg.bank;
    assign m_write_address = WADDR_W'(slot0_reg.addr);
    assign m_written_word  = slot0_reg.word;
    assign m_is_timestamp  = slot0_reg.is_ts;
    assign m_flush_valid   = slot0_reg.flush_valid;
    assign m_flush_bank    = slot0_reg.flush_bank;
    assign m_flush_bytes   = slot0_reg.flush_bytes;
    assign m_dropped       = slot0_reg.dropped;
    assign m_last          = slot0_reg.last;

endmodule
`default_nettype wire

// File: src/ptl_checker.sv
// Port-level checker for the timestamp logger and its bind to the top level.
`default_nettype none
`include "pingpong_timestamp_logger_top_assert.svh"
module ptl_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic                        m_write_bank,
    input wire logic                        m_is_timestamp,
    input wire logic                        m_flush_valid,
    input wire logic                        m_flush_bank,
    input wire logic [ptl_pkg::BYTES_W-1:0] m_flush_bytes,
    input wire logic                        m_last
);
    import ptl_pkg::*;

    // A pending result is not withdrawn
    `PTL_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // After a handoff the word lands in the other bank
    `PTL_ASSERT_NOW(a_flush_switch, aclk, aresetn, m_valid && m_flush_valid, m_flush_bank != m_write_bank)

    // No descriptor fields without a flush
    `PTL_ASSERT_NOW(a_flush_quiet, aclk, aresetn, m_valid && !m_flush_valid, (m_flush_bank == 1'b0) && (m_flush_bytes == '0))

    // The timestamp always closes its item
    `PTL_ASSERT_NOW(a_ts_last, aclk, aresetn, m_valid && m_is_timestamp, m_last)

    // Input stalls while a record's timestamp still waits behind its data word
    `PTL_ASSERT_NOW(a_pair_stall, aclk, aresetn, m_valid && !m_last, !s_ready)

endmodule

bind pingpong_timestamp_logger_top ptl_checker u_ptl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_write_bank   (m_write_bank),
    .m_is_timestamp (m_is_timestamp),
    .m_flush_valid  (m_flush_valid),
    .m_flush_bank   (m_flush_bank),
    .m_flush_bytes  (m_flush_bytes),
    .m_last         (m_last)
);
`default_nettype wire

// File: verif/pingpong_timestamp_logger_top_tb.sv
// Self-checking testbench for the ping-pong timestamp logger: directed, bank-end and random runs.
module pingpong_timestamp_logger_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptl_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    // One expected bank write, laid out like the result channel
    typedef struct packed {
        logic               bank;
        logic [WADDR_W-1:0] addr;
        logic [DATA_W-1:0]  word;
        logic               is_ts;
        logic               flush_valid;
        logic               flush_bank;
        logic [BYTES_W-1:0] flush_bytes;
        logic               dropped;
        logic               last;
    } bank_write_t;

    logic                 aclk;
    logic                 aresetn         = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [LEN_W-1:0]     cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [DATA_W-1:0]    s_data_word     = '0;
    logic [LEN_W-1:0]     s_record_length = '0;
    logic [TIMER_W-1:0]   s_timer_sample  = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_write_bank;
    logic [WADDR_W-1:0]   m_write_address;
    logic [DATA_W-1:0]    m_written_word;
    logic                 m_is_timestamp;
    logic                 m_flush_valid;
    logic                 m_flush_bank;
    logic [BYTES_W-1:0]   m_flush_bytes;
    logic                 m_dropped;
    logic                 m_last;

    // Shadow of the logger state
    int   fill_b0;
    int   fill_b1;
    logic act_bank;
    int   rec_pos;
    int   limit_model;

    bank_write_t bank_writes_due[$];

    int err_count;
    int tx_count;
    int n_items;
    int n_results;
    int n_flush;
    int n_drop;
    int n_stamp;
    int rx_hold_req;
    bit tx_idle_en;
    bit rx_idle_en;

    pingpong_timestamp_logger_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_word     (s_data_word),
        .s_record_length (s_record_length),
        .s_timer_sample  (s_timer_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_bank    (m_write_bank),
        .m_write_address (m_write_address),
        .m_written_word  (m_written_word),
        .m_is_timestamp  (m_is_timestamp),
        .m_flush_valid   (m_flush_valid),
        .m_flush_bank    (m_flush_bank),
        .m_flush_bytes   (m_flush_bytes),
        .m_dropped       (m_dropped),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Record length: mostly short records, a few long ones
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return LEN_W'($urandom_range(0, 3));
        end else if (r < 80) begin
            return LEN_W'($urandom_range(4, 16));
        end else if (r < 96) begin
            return LEN_W'($urandom_range(17, 64));
        end
        return LEN_W'($urandom_range(65, 160));
    endfunction

    // Exact single-precision encoding of a 16-bit timer value
    function automatic logic [31:0] timer_as_float(input logic [TIMER_W-1:0] v);
        int          msb;
        int          i;
        logic [31:0] frac;
        msb = 0;
        for (i = 0; i < TIMER_W; i++) begin
            if (v[i]) begin
                msb = i;
            end
        end
        frac = ({16'd0, v} << (23 - msb)) & 32'h007F_FFFF;
        if (v == '0) begin
            return 32'd0;
        end
        return {1'b0, 8'(127 + msb), frac[22:0]};
    endfunction

    // Append one word to the active bank; past the bank end it is dropped
    function automatic bank_write_t store_word(input logic [DATA_W-1:0] w, input logic stamp);
        bank_write_t r;
        int          addr;
        addr = act_bank ? fill_b1 : fill_b0;
        r = '0;
        r.bank    = act_bank;
        r.addr    = addr[WADDR_W-1:0];
        r.word    = w;
        r.is_ts   = stamp;
        r.dropped = (addr >= BANK_DEPTH);
        if (addr < BANK_DEPTH) begin
            if (act_bank) begin
                fill_b1 = addr + 1;
            end else begin
                fill_b0 = addr + 1;
            end
        end
        return r;
    endfunction

    // Work out the bank writes caused by one accepted input word
    function automatic void predict_bank_writes(input logic [DATA_W-1:0] data,
                                                input logic [LEN_W-1:0] len,
                                                input logic [TIMER_W-1:0] ts);
        bank_write_t first;
        bank_write_t second;
        logic               do_flush;
        logic               fbank;
        logic [BYTES_W-1:0] fbytes;
        int                 fill_now;
        int                 bytes_full;
        int                 len_i;
        int                 n;
        logic [31:0]        stamp;
        do_flush = 1'b0;
        fbank    = 1'b0;
        fbytes   = '0;
        len_i    = int'(len);
        stamp    = timer_as_float(ts);
        second   = '0;

        // Flush check at the start of a record
        if (rec_pos == 0) begin
            fill_now = act_bank ? fill_b1 : fill_b0;
            if (fill_now + len_i + 1 > limit_model) begin
                do_flush   = 1'b1;
                fbank      = act_bank;
                bytes_full = fill_now * 4;
                fbytes     = bytes_full[BYTES_W-1:0];
                if (act_bank) begin
                    fill_b1 = 0;
                end else begin
                    fill_b0 = 0;
                end
                act_bank = ~act_bank;
            end
        end

        if (len_i == 0) begin
            first   = store_word(stamp, 1'b1);
            n       = 1;
            rec_pos = 0;
        end else begin
            first = store_word(data, 1'b0);
            n     = 1;
            if (rec_pos + 1 >= len_i) begin
                second  = store_word(stamp, 1'b1);
                n       = 2;
                rec_pos = 0;
            end else begin
                rec_pos = (rec_pos + 1) % 512;
            end
        end

        if (do_flush) begin
            first.flush_valid = 1'b1;
            first.flush_bank  = fbank;
            first.flush_bytes = fbytes;
            n_flush++;
        end
        if (n == 1) begin
            first.last = 1'b1;
            bank_writes_due.push_back(first);
        end else begin
            second.last = 1'b1;
            bank_writes_due.push_back(first);
            bank_writes_due.push_back(second);
        end
    endfunction

    // Input monitor: predict on each accepted transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            n_items++;
            predict_bank_writes(s_data_word, s_record_length, s_timer_sample);
        end
    end

    // Result checker: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        bank_write_t got;
        bank_write_t want;
        if (aresetn && m_valid && m_ready) begin
            got.bank        = m_write_bank;
            got.addr        = m_write_address;
            got.word        = m_written_word;
            got.is_ts       = m_is_timestamp;
            got.flush_valid = m_flush_valid;
            got.flush_bank  = m_flush_bank;
            got.flush_bytes = m_flush_bytes;
            got.dropped     = m_dropped;
            got.last        = m_last;
            n_results++;
            if (bank_writes_due.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("ERROR: result with nothing expected: bank %0d addr %0d word %h",
                             got.bank, got.addr, got.word);
                end
            end else begin
                want = bank_writes_due.pop_front();
                if (want.dropped) n_drop++;
                if (want.is_ts) n_stamp++;
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("ERROR: result %0d mismatch", n_results);
                        $display("  exp bank %0d addr %0d word %h ts %0d",
                                 want.bank, want.addr, want.word, want.is_ts);
                        $display("      flush %0d/%0d/%0d drop %0d last %0d",
                                 want.flush_valid, want.flush_bank, want.flush_bytes,
                                 want.dropped, want.last);
                        $display("  got bank %0d addr %0d word %h ts %0d",
                                 got.bank, got.addr, got.word, got.is_ts);
                        $display("      flush %0d/%0d/%0d drop %0d last %0d",
                                 got.flush_valid, got.flush_bank, got.flush_bytes,
                                 got.dropped, got.last);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int run_left;
        int stall_left;
        int hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (run_left > 0) begin
                m_ready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready    <= 1'b1;
                run_left   = $urandom_range(0, 20);
                stall_left = rx_idle_en ? pick_gap() : 0;
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, bank_writes_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one word and hold it until the transfer happens
    task automatic send_word(input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len,
                             input logic [TIMER_W-1:0] ts);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_word     <= data;
        s_record_length <= len;
        s_timer_sample  <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tx_count++;
    endtask

    // A well-formed record: every word carries the same length
    task automatic send_record(input logic [LEN_W-1:0] len);
        int i;
        int words;
        words = (len == '0) ? 1 : int'(len);
        for (i = 0; i < words; i++) begin
            send_word($urandom, len, TIMER_W'($urandom_range(0, 65535)));
        end
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bank_writes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_fill_limit(input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(value);
        @(posedge aclk);
        cfg_we      <= 1'b0;
        limit_model = value;
    endtask

    // Field extremes, empty records and length changes at the reset limit
    task automatic test_reset_limit();
        send_word(32'h0000_0000, 9'd0, 16'h0000);
        send_word(32'hFFFF_FFFF, 9'd0, 16'hFFFF);
        send_word(32'hFFFF_FFFF, 9'd1, 16'h0001);
        send_word(32'h0000_0000, 9'd1, 16'h8000);
        send_word(32'hA5A5_A5A5, 9'd3, 16'h5555);
        send_word(32'h5A5A_5A5A, 9'd3, 16'h1234);
        send_word(32'h1234_5678, 9'd3, 16'hAAAA);
        // length shrinks mid-record, record closes early
        send_word(32'h0000_0001, 9'd5, 16'h0000);
        send_word(32'h0000_0002, 9'd5, 16'h0000);
        send_word(32'h0000_0003, 9'd2, 16'h00FF);
        // length grows mid-record, record runs on
        send_word(32'h0000_0004, 9'd2, 16'h0003);
        send_word(32'h0000_0005, 9'd6, 16'h0007);
        send_word(32'h0000_0006, 9'd3, 16'h7FFF);
        // longest record that fits the reset limit forces a flush, then closes at once
        send_word(32'hDEAD_BEEF, 9'd510, 16'hFFFE);
        send_word(32'hCAFE_F00D, 9'd1, 16'h0100);
    endtask

    // Limits of zero and one: every record, or nearly so, flushes first
    task automatic test_limit_extremes();
        write_fill_limit(0);
        send_word($urandom, 9'd0, 16'h0002);
        send_word($urandom, 9'd0, 16'h0004);
        send_word($urandom, 9'd0, 16'h0008);
        send_record(9'd2);
        write_fill_limit(1);
        send_word($urandom, 9'd0, 16'h0010);
        send_word($urandom, 9'd0, 16'h0020);
        send_record(9'd1);
        send_record(9'd3);
    endtask

    // One-word records fill the bank, then a record grows past the bank end
    task automatic test_bank_end();
        int i;
        write_fill_limit(0);
        send_record(9'd0);
        send_record(9'd0);
        write_fill_limit(511);
        // each one-word record stores two words
        while ((act_bank ? fill_b1 : fill_b0) < 496) begin
            send_record(9'd1);
        end
        send_word($urandom, 9'd2, TIMER_W'($urandom_range(0, 65535)));
        for (i = 1; i < 24; i++) begin
            send_word($urandom, 9'd24, TIMER_W'($urandom_range(0, 65535)));
        end
        // next record hands off the overfull bank
        send_record(9'd1);
    endtask

    // Mostly well-formed records with random content, some broken sequences
    task automatic test_random_records(input int count);
        int start;
        int i;
        int pieces;
        start = tx_count;
        while (tx_count - start < count) begin
            if ($urandom_range(0, 99) < 80) begin
                send_record(pick_len());
            end else begin
                pieces = $urandom_range(1, 6);
                for (i = 0; i < pieces; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_word($urandom, LEN_W'($urandom_range(0, 510)),
                                  TIMER_W'($urandom_range(0, 65535)));
                    end else begin
                        send_word($urandom, LEN_W'($urandom_range(0, 12)),
                                  TIMER_W'($urandom_range(0, 65535)));
                    end
                end
            end
        end
    endtask

    // Long receiver hold-off while the sender keeps offering words
    task automatic test_output_backpressure();
        settle();
        tx_idle_en  = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        test_random_records(30);
        settle();
        tx_idle_en = 1'b1;
    endtask

    initial begin
        fill_b0     = 0;
        fill_b1     = 0;
        act_bank    = 1'b0;
        rec_pos     = 0;
        limit_model = int'(FILL_LIMIT_RESET);
        err_count   = 0;
        tx_count    = 0;
        n_items     = 0;
        n_results   = 0;
        n_flush     = 0;
        n_drop      = 0;
        n_stamp     = 0;
        rx_hold_req = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_limit();
        test_limit_extremes();
        test_bank_end();

        write_fill_limit(511);
        test_random_records(40);
        write_fill_limit($urandom_range(8, 40));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_records(30);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_fill_limit(1);
        test_random_records(20);
        write_fill_limit($urandom_range(1, 511));
        test_random_records(40);
        write_fill_limit($urandom_range(40, 200));
        test_random_records(30);
        test_output_backpressure();

        settle();
        $display("Covered %0d input and %0d result transfers", n_items, n_results);
        $display("  %0d flushes, %0d dropped, %0d stamps; limits zero to max, bank overflow",
                 n_flush, n_drop, n_stamp);
        if (err_count == 0 && bank_writes_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
